// ----- rtl/core/wfa_pkg.sv -----
// ----------------------------------------------------------------------------
// wfa_pkg
// shared types and constants of the weighted frame accumulator
// ----------------------------------------------------------------------------
package wfa_pkg;

    localparam logic [23:0] Q_ONE = 24'h010000;

    typedef enum logic [1:0] {
        OP_ACC_ONE  = 2'd0,
        OP_ACC_PAIR = 2'd1,
        OP_SCALE    = 2'd2,
        OP_EMIT     = 2'd3
    } opcode_t;

    // class of a queued transaction, settled by the front end
    typedef enum logic [2:0] {
        K_ACC_ONE,
        K_ACC_PAIR,
        K_SKIP,
        K_CLEAR,
        K_SCALE,
        K_EMIT
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_ADD,
        ST_SLO,
        ST_SHI,
        ST_SFIN,
        ST_NORM,
        ST_NFIN,
        ST_EMIT
    } back_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [17:0] pixel_index;
        logic        in_range;
        logic [8:0]  sum;
        logic [23:0] weight;
        logic [23:0] factor;
        logic        last;
    } entry_t;

endpackage

// ----- rtl/core/wfa_ram.sv -----
// ----------------------------------------------------------------------------
// wfa_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module wfa_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 262144
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/wfa_front.sv -----
// ----------------------------------------------------------------------------
// wfa_front
// accepts transactions, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module wfa_front
    import wfa_pkg::*;
#(
    parameter int MAX_PIXELS = 262144
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        enable,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [17:0] pixel_index,
    input  logic [7:0]  pixel_a,
    input  logic [7:0]  pixel_b,
    input  logic [23:0] weight,
    input  logic [23:0] scale_factor,
    input  logic        last_pixel,
    output logic        q_valid,
    output entry_t      q_entry,
    input  logic        q_pop
);

    entry_t     slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    entry_t     cls;
    logic       push;

    // classification
    always_comb
    begin
        cls.pixel_index = pixel_index;
        cls.in_range    = 32'(pixel_index) < 32'(MAX_PIXELS);
        cls.weight      = weight;
        cls.factor      = scale_factor;
        cls.last        = last_pixel;
        cls.sum         = 9'(pixel_a);
        unique case (opcode_t'(opcode))
            OP_ACC_ONE:  cls.kind = K_ACC_ONE;
            OP_ACC_PAIR:
            begin
                cls.kind = K_ACC_PAIR;
                cls.sum  = 9'(pixel_a) + 9'(pixel_b);
            end
            OP_SCALE:
            begin
                if (scale_factor == Q_ONE)
                    cls.kind = K_SKIP;
                else if (scale_factor == 24'd0)
                    cls.kind = K_CLEAR;
                else
                    cls.kind = K_SCALE;
            end
            OP_EMIT:     cls.kind = K_EMIT;
            default:     cls.kind = K_SKIP;
        endcase
    end

    assign in_ready = enable && (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = count_reg != 2'd0;
    assign q_entry  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ----- rtl/core/wfa_back.sv -----
// ----------------------------------------------------------------------------
// wfa_back
// sequencer: store clearing, read-modify-write, scaling and normalization
// ----------------------------------------------------------------------------
module wfa_back
    import wfa_pkg::*;
#(
    parameter int MAX_PIXELS = 262144,
    parameter int ACCUM_BITS = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    output logic        clearing,
    input  logic        q_valid,
    input  entry_t      q_entry,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [17:0] out_index,
    output logic [7:0]  out_pixel,
    output logic        out_last
);

    localparam int W      = ACCUM_BITS;
    localparam int DEPTH  = (MAX_PIXELS > 262144) ? 262144 : MAX_PIXELS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [W-1:0]      MAXV      = {W{1'b1}};
    localparam logic [ADDR_W:0]   LAST_ADDR = (ADDR_W + 1)'(DEPTH - 1);

    back_state_t      st_reg, st_next;
    entry_t           ent_reg, ent_next;
    logic [W-1:0]     white_reg, white_next;
    logic [ADDR_W:0]  clr_reg, clr_next;
    logic             phase_reg, phase_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    logic [W-1:0]     cur_reg, cur_next;
    logic [W-1:0]     opnd_reg, opnd_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [7:0]       quo_reg, quo_next;
    logic [55:0]      lo_reg, lo_next;
    logic [55:0]      hi_reg, hi_next;
    logic [32:0]      prod_reg, prod_next;
    logic [33:0]      wprod_reg, wprod_next;
    logic [17:0]      oidx_reg, oidx_next;
    logic [7:0]       opix_reg, opix_next;
    logic             olast_reg, olast_next;

    logic             we;
    logic [ADDR_W-1:0] waddr;
    logic [W-1:0]     wdata;
    logic [W-1:0]     rdata;

    logic [63:0]      opnd64;
    logic [55:0]      lo_round;
    logic [64:0]      scale_sum;
    logic [W-1:0]     scaled;
    logic [W-1:0]     diff;

    function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [33:0] b);
        logic [64:0] s;
        s = 65'(a) + 65'(b);
        if ((s >> W) != 65'd0)
            return MAXV;
        return s[W-1:0];
    endfunction

    wfa_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (q_pop),
        .raddr (q_entry.pixel_index[ADDR_W-1:0]),
        .rdata (rdata)
    );

    // rounded Q16 product recombined from the two partial products
    assign opnd64    = 64'(opnd_reg);
    assign lo_round  = lo_reg + 56'h8000;
    assign scale_sum = 65'({hi_reg[47:0], 16'd0}) + 65'(lo_round[55:16]);
    assign scaled    = ((hi_reg[55:48] != 8'd0) || ((scale_sum >> W) != 65'd0))
                       ? MAXV : scale_sum[W-1:0];
    assign diff      = white_reg - rem_reg;

    assign clearing  = st_reg == ST_CLEAR;
    assign q_pop     = (st_reg == ST_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign out_index = oidx_reg;
    assign out_pixel = opix_reg;
    assign out_last  = olast_reg;

    always_comb
    begin
        st_next        = st_reg;
        ent_next       = ent_reg;
        white_next     = white_reg;
        clr_next       = clr_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cur_next       = cur_reg;
        opnd_next      = opnd_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        prod_next      = prod_reg;
        wprod_next     = wprod_reg;
        oidx_next      = oidx_reg;
        opix_next      = opix_reg;
        olast_next     = olast_reg;
        we             = 1'b0;
        waddr          = ent_reg.pixel_index[ADDR_W-1:0];
        wdata          = '0;

        unique case (st_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg[ADDR_W-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                    st_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    ent_next = q_entry;
                    st_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cur_next = ent_reg.in_range ? rdata : '0;
                st_next  = ST_IDLE;
                unique case (ent_reg.kind)
                    K_ACC_ONE, K_ACC_PAIR:
                        st_next = ST_MUL;
                    K_SKIP:
                        st_next = ST_IDLE;
                    K_CLEAR, K_SCALE:
                    begin
                        if (ent_reg.kind == K_CLEAR || white_reg == '0)
                        begin
                            we = ent_reg.in_range;
                            if (ent_reg.last)
                                white_next = '0;
                        end
                        else
                        begin
                            opnd_next  = ent_reg.in_range ? rdata : '0;
                            phase_next = 1'b0;
                            st_next    = ST_SLO;
                        end
                    end
                    K_EMIT:
                    begin
                        rem_next = ent_reg.in_range ? rdata : '0;
                        quo_next = 8'd0;
                        cnt_next = 3'd0;
                        if (white_reg == '0)
                        begin
                            quo_next = 8'd0;
                            st_next  = ST_EMIT;
                        end
                        else if ((ent_reg.in_range ? rdata : '0) >= white_reg)
                        begin
                            quo_next = 8'hff;
                            st_next  = ST_EMIT;
                        end
                        else
                            st_next = ST_NORM;
                    end
                    default:
                        st_next = ST_IDLE;
                endcase
            end
            ST_MUL:
            begin
                prod_next = 33'(ent_reg.weight) * 33'(ent_reg.sum);
                // weight times 255, or 510 for a pair
                if (ent_reg.kind == K_ACC_PAIR)
                    wprod_next = (34'(ent_reg.weight) << 9) - (34'(ent_reg.weight) << 1);
                else
                    wprod_next = (34'(ent_reg.weight) << 8) - 34'(ent_reg.weight);
                st_next = ST_ADD;
            end
            ST_ADD:
            begin
                we    = ent_reg.in_range;
                wdata = sat_add(cur_reg, 34'(prod_reg));
                if (ent_reg.last)
                    white_next = sat_add(white_reg, wprod_reg);
                st_next = ST_IDLE;
            end
            ST_SLO:
            begin
                lo_next = 56'(opnd64[31:0]) * 56'(ent_reg.factor);
                st_next = ST_SHI;
            end
            ST_SHI:
            begin
                hi_next = 56'(opnd64[63:32]) * 56'(ent_reg.factor);
                st_next = ST_SFIN;
            end
            ST_SFIN:
            begin
                st_next = ST_IDLE;
                if (phase_reg)
                    white_next = scaled;
                else
                begin
                    we    = ent_reg.in_range;
                    wdata = scaled;
                    if (ent_reg.last)
                    begin
                        opnd_next  = white_reg;
                        phase_next = 1'b1;
                        st_next    = ST_SLO;
                    end
                end
            end
            ST_NORM:
            begin
                // one quotient bit of 256*a/w per cycle
                if (rem_reg >= diff)
                begin
                    rem_next = rem_reg - diff;
                    quo_next = {quo_reg[6:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_reg + rem_reg;
                    quo_next = {quo_reg[6:0], 1'b0};
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                    st_next = ST_NFIN;
            end
            ST_NFIN:
            begin
                quo_next = (rem_reg >= cur_reg) ? quo_reg : quo_reg - 8'd1;
                st_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                // byte waits in quo_reg until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    oidx_next      = ent_reg.pixel_index;
                    opix_next      = quo_reg;
                    olast_next     = ent_reg.last;
                    st_next        = ST_IDLE;
                end
            end
            default:
                st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_CLEAR;
            white_reg     <= '0;
            clr_reg       <= '0;
            phase_reg     <= 1'b0;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            white_reg     <= white_next;
            clr_reg       <= clr_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg   <= ent_next;
        cur_reg   <= cur_next;
        opnd_reg  <= opnd_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        prod_reg  <= prod_next;
        wprod_reg <= wprod_next;
        oidx_reg  <= oidx_next;
        opix_reg  <= opix_next;
        olast_reg <= olast_next;
    end

endmodule

// ----- rtl/core/weighted_frame_accumulator.sv -----
// ----------------------------------------------------------------------------
// weighted_frame_accumulator
// motion-blur frame accumulator: weighted pixel sums, scaling, normalized emit
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | opcode pixel_index pixel_a pixel_b weight
//          |                      | scale_factor last_pixel
//  out     | out_valid / out_ready| out_index out_pixel out_last
//
//  after reset the store is cleared, one entry per cycle, MAX_PIXELS entries
//  (capped at 262144); in_ready stays low during that pass
//  transactions go one at a time through the single back end sequencer and
//  the one store port; scale with last_pixel also scales white, and emit
//  skips normalization when white is zero or the sum reaches white
//  a two-entry queue lets the front accept while the back end works or while
//  a result waits in the output register
// ----------------------------------------------------------------------------
module weighted_frame_accumulator
    import wfa_pkg::*;
#(
    parameter int MAX_PIXELS = 262144,
    parameter int ACCUM_BITS = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [17:0] pixel_index,
    input  logic [7:0]  pixel_a,
    input  logic [7:0]  pixel_b,
    input  logic [23:0] weight,
    input  logic [23:0] scale_factor,
    input  logic        last_pixel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [17:0] out_index,
    output logic [7:0]  out_pixel,
    output logic        out_last
);

    logic   clearing;
    logic   q_valid;
    logic   q_pop;
    entry_t q_entry;

    // front: classify each transaction and queue it
    wfa_front #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .enable       (!clearing),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .pixel_index  (pixel_index),
        .pixel_a      (pixel_a),
        .pixel_b      (pixel_b),
        .weight       (weight),
        .scale_factor (scale_factor),
        .last_pixel   (last_pixel),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_pop        (q_pop)
    );

    // back: store read-modify-write, white point, normalization, output reg
    wfa_back #(
        .MAX_PIXELS (MAX_PIXELS),
        .ACCUM_BITS (ACCUM_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_index (out_index),
        .out_pixel (out_pixel),
        .out_last  (out_last)
    );

endmodule

// ----- tb/weighted_frame_accumulator_tb.sv -----
// ----------------------------------------------------------------------------
// weighted_frame_accumulator_tb
// self-checking bench: a directed table of pixel transactions, then random
// frames on a small pool of store entries, with gaps and stalls on both
// channels, every emitted byte checked against a behavioral model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module weighted_frame_accumulator_tb;
    import wfa_pkg::*;

    localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;
    localparam int RANDOM_ITEMS = 830;

    typedef struct {
        opcode_t     op;
        logic [17:0] idx;
        logic [7:0]  pa;
        logic [7:0]  pb;
        logic [23:0] wt;
        logic [23:0] fac;
        logic        last;
        int          typed_pixel; // -1: take the model's byte
    } pixel_txn_t;

    typedef struct {
        logic [17:0] idx;
        logic [7:0]  pixel;
        logic        last;
    } emit_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [17:0] pixel_index;
    logic [7:0]  pixel_a;
    logic [7:0]  pixel_b;
    logic [23:0] weight;
    logic [23:0] scale_factor;
    logic        last_pixel;
    logic        out_valid;
    logic        out_ready;
    logic [17:0] out_index;
    logic [7:0]  out_pixel;
    logic        out_last;

    // model state: sparse copy of the store plus the white point
    logic [47:0] sum_mem [int];
    logic [47:0] white_pt;

    emit_t       emit_q [$];
    pixel_txn_t  table_q [$];
    int          errors;
    int          n_sent;
    int          n_emits;
    int          n_white_sat;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_req;
    bit          stim_done;

    weighted_frame_accumulator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .pixel_index  (pixel_index),
        .pixel_a      (pixel_a),
        .pixel_b      (pixel_b),
        .weight       (weight),
        .scale_factor (scale_factor),
        .last_pixel   (last_pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_index    (out_index),
        .out_pixel    (out_pixel),
        .out_last     (out_last)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    function automatic logic [47:0] sat_sum(input logic [47:0] x, input logic [47:0] y);
        logic [48:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[48] ? SUM_MAX : s[47:0];
    endfunction

    // round half up of value*factor in Q8.16, saturating
    function automatic logic [47:0] q16_scaled(input logic [47:0] v, input logic [23:0] f);
        logic [71:0] p;
        p = 72'(v) * 72'(f) + 72'h8000;
        p = p >> 16;
        return (p > 72'(SUM_MAX)) ? SUM_MAX : p[47:0];
    endfunction

    function automatic logic [7:0] norm_byte(input logic [47:0] a, input logic [47:0] w);
        logic [63:0] q;
        if (w == 0)
            return 8'd0;
        if (a >= w)
            return 8'd255;
        q = (64'(a) * 64'd255) / 64'(w);
        return q[7:0];
    endfunction

    // apply one accepted transaction to the model, returns 1 on an emit
    function automatic bit predict_pixel(input pixel_txn_t t, output emit_t e);
        logic [47:0] cur;
        logic [8:0]  s;
        cur = sum_mem.exists(int'(t.idx)) ? sum_mem[int'(t.idx)] : 48'd0;
        e = '{idx: t.idx, pixel: 8'd0, last: t.last};
        case (t.op)
            OP_ACC_ONE, OP_ACC_PAIR:
            begin
                s = (t.op == OP_ACC_PAIR) ? 9'(t.pa) + 9'(t.pb) : 9'(t.pa);
                sum_mem[int'(t.idx)] = sat_sum(cur, 48'(t.wt) * 48'(s));
                if (t.last)
                    white_pt = sat_sum(white_pt, 48'(t.wt)
                        * ((t.op == OP_ACC_PAIR) ? 48'd510 : 48'd255));
                if (white_pt == SUM_MAX)
                    n_white_sat++;
                return 0;
            end
            OP_SCALE:
            begin
                if (t.fac == Q_ONE)
                    return 0;
                if (t.fac == 0 || white_pt == 0)
                begin
                    sum_mem[int'(t.idx)] = 48'd0;
                    if (t.last)
                        white_pt = 48'd0;
                    return 0;
                end
                sum_mem[int'(t.idx)] = q16_scaled(cur, t.fac);
                if (t.last)
                    white_pt = q16_scaled(white_pt, t.fac);
                return 0;
            end
            default:
            begin
                e.pixel = norm_byte(cur, white_pt);
                return 1;
            end
        endcase
    endfunction

    task automatic add_row(input opcode_t op, input int idx, input int pa, input int pb,
                           input int wt, input int fac, input bit last, input int typed);
        table_q.push_back('{op, 18'(idx), 8'(pa), 8'(pb), 24'(wt), 24'(fac), last, typed});
    endtask

    // offer one transaction, hold it until accepted, then predict
    task automatic send_pixel(input pixel_txn_t t);
        emit_t e;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        opcode       <= t.op;
        pixel_index  <= t.idx;
        pixel_a      <= t.pa;
        pixel_b      <= t.pb;
        weight       <= t.wt;
        scale_factor <= t.fac;
        last_pixel   <= t.last;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (predict_pixel(t, e))
        begin
            if (t.typed_pixel >= 0)
            begin
                if (e.pixel != 8'(t.typed_pixel))
                    report_mismatch("table entry vs model", e.pixel, t.typed_pixel);
                e.pixel = 8'(t.typed_pixel);
            end
            emit_q.push_back(e);
            n_emits++;
        end
        n_sent++;
        @(negedge clk);
    endtask

    // random transaction on a small pool of entries, so sums build up and
    // get emitted; now and then any index and any weight
    function automatic pixel_txn_t rand_pixel();
        pixel_txn_t t;
        int r;
        r = $urandom_range(99);
        t.op = (r < 35) ? OP_ACC_ONE : (r < 55) ? OP_ACC_PAIR : (r < 72) ? OP_SCALE : OP_EMIT;
        t.idx = ($urandom_range(9) == 0) ? 18'($urandom) : 18'($urandom_range(7));
        t.pa = 8'($urandom);
        t.pb = 8'($urandom);
        case ($urandom_range(3))
            0: t.wt = 24'($urandom);
            1: t.wt = 24'($urandom_range(32'h20000));
            2: t.wt = Q_ONE;
            default: t.wt = 24'($urandom_range(32'h4000));
        endcase
        case ($urandom_range(5))
            0: t.fac = Q_ONE;
            1: t.fac = 24'd0;
            2: t.fac = 24'($urandom);
            default: t.fac = 24'($urandom_range(32'h4000, 32'h10000));
        endcase
        t.last = ($urandom_range(6) == 0);
        t.typed_pixel = -1;
        return t;
    endfunction

    // result checker, samples on the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (emit_q.size() == 0)
                report_mismatch("unexpected output transaction, index", out_index, -1);
            else
            begin
                emit_t e;
                e = emit_q.pop_front();
                if (out_index != e.idx)
                    report_mismatch("out_index", out_index, e.idx);
                if (out_pixel != e.pixel)
                    report_mismatch("out_pixel", out_pixel, e.pixel);
                if (out_last != e.last)
                    report_mismatch("out_last", out_last, e.last);
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int held;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                for (held = 0; held < 400; held++)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // limit: clearing pass after reset plus the slowest run, several times over
    initial
    begin
        #20ms;
        $display("weighted_frame_accumulator_tb: done, errors");
        $finish;
    end

    initial
    begin
        int i;
        int waited;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_ACC_ONE;
        pixel_index = '0;
        pixel_a = '0;
        pixel_b = '0;
        weight = '0;
        scale_factor = '0;
        last_pixel = 1'b0;
        white_pt = '0;
        errors = 0;
        n_sent = 0;
        n_emits = 0;
        n_white_sat = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        stim_done = 1'b0;

        // directed table: zero white, full scale, saturation, scale special cases
        add_row(OP_EMIT,      0,      0,   0,   0,        0,        1, 0);
        add_row(OP_ACC_ONE,   0,      255, 0,   'h10000,  0,        1, -1);
        add_row(OP_EMIT,      0,      0,   0,   0,        0,        1, 255);
        add_row(OP_ACC_PAIR,  262143, 255, 255, 'hFFFFFF, 0,        0, -1);
        add_row(OP_EMIT,      262143, 0,   0,   0,        0,        0, 255);
        add_row(OP_ACC_ONE,   5,      0,   0,   'hFFFFFF, 0,        0, -1);
        add_row(OP_EMIT,      5,      0,   0,   0,        0,        0, 0);
        add_row(OP_SCALE,     0,      0,   0,   0,        'h10000,  1, -1);
        add_row(OP_SCALE,     0,      0,   0,   0,        'h8000,   0, -1);
        add_row(OP_EMIT,      0,      0,   0,   0,        0,        0, -1);
        add_row(OP_SCALE,     262143, 0,   0,   0,        'hFFFFFF, 0, -1);
        add_row(OP_ACC_ONE,   262143, 255, 0,   'hFFFFFF, 0,        0, -1);
        add_row(OP_EMIT,      262143, 0,   0,   0,        0,        1, 255);
        add_row(OP_ACC_PAIR,  7,      1,   0,   1,        0,        1, -1);
        add_row(OP_ACC_PAIR,  7,      0,   170, 'h5A5A5A, 0,        0, -1);
        add_row(OP_EMIT,      7,      0,   0,   0,        0,        0, -1);
        add_row(OP_SCALE,     3,      0,   0,   0,        0,        1, -1);
        add_row(OP_EMIT,      0,      0,   0,   0,        0,        0, 0);
        add_row(OP_ACC_ONE,   9,      128, 0,   'h10000,  0,        1, -1);
        add_row(OP_SCALE,     9,      0,   0,   0,        'h20000,  1, -1);
        add_row(OP_SCALE,     9,      0,   0,   0,        'h0001,   0, -1);
        add_row(OP_EMIT,      9,      0,   0,   0,        0,        1, -1);
        add_row(OP_SCALE,     9,      0,   0,   0,        'hA5A5A5, 1, -1);
        add_row(OP_EMIT,      262143, 0,   0,   0,        0,        0, -1);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (table_q[k])
            send_pixel(table_q[k]);

        // random part in four idling phases; long hold-off early on
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            case (i * 4 / RANDOM_ITEMS)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            if (i == 20)
                hold_req = 1'b1;
            send_pixel(rand_pixel());
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;

        waited = 0;
        while (emit_q.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        if (emit_q.size() != 0)
            report_mismatch("results still outstanding", emit_q.size(), 0);
        repeat (50) @(posedge clk);
        if (emit_q.size() != 0)
            report_mismatch("results still outstanding", emit_q.size(), 0);

        $display("covered %0d pixel transactions, %0d emits, white point saturated %0d times",
                 n_sent, n_emits, n_white_sat);
        $display("mismatches: %0d", errors);
        if (errors == 0)
            $display("weighted_frame_accumulator_tb: done, clean");
        else
            $display("weighted_frame_accumulator_tb: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/wfa_pkg.sv
rtl/core/wfa_ram.sv
rtl/core/wfa_front.sv
rtl/core/wfa_back.sv
rtl/core/weighted_frame_accumulator.sv
tb/weighted_frame_accumulator_tb.sv
